// ===== rtl/frame_time_window_stats_macros.svh =====
// Assertion macros for the frame time window statistics block.
// Used by the bound checker; needs nothing else.
`ifndef FRAME_TIME_WINDOW_STATS_MACROS_SVH
`define FRAME_TIME_WINDOW_STATS_MACROS_SVH

// same-cycle implication, reset masked
`define FTWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame time stats check failed");

// next-cycle implication, reset masked
`define FTWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame time stats check failed");

`endif

// ===== rtl/ftws_pkg.sv =====
// Shared types and constants for the frame time window statistics block.
// No dependencies; used by the top level, the divider and the checker.
package ftws_pkg;

	localparam int TIME_W  = 24;
	localparam int RATE_W  = 28;
	localparam int COUNT_W = 32;
	localparam int TOTAL_W = 48;

	// samples held in the ring
	localparam int WINDOW = 120;
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SUM_W  = TIME_W + FILL_W;

	// shared divider: dividend covers the window sum and the rate numerator
	localparam int DIV_N_W    = (SUM_W > RATE_W) ? SUM_W : RATE_W;
	localparam int DIV_D_W    = TIME_W;
	localparam int DIV_STEP_W = $clog2(DIV_N_W);

	localparam logic [TIME_W-1:0] MIN_CEILING = TIME_W'(9999000);
	localparam logic [RATE_W-1:0] RATE_NUM    = RATE_W'(256000000);

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		DIV_MEAN      = 3'd0,
		DIV_CUR_RATE  = 3'd1,
		DIV_MEAN_RATE = 3'd2,
		DIV_LOW_RATE  = 3'd3,
		DIV_HIGH_RATE = 3'd4
	} div_op_t;

	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] frame_time_us;
	} sample_t;

	typedef struct packed {
		logic [TIME_W-1:0]  cur_time_us;
		logic [TIME_W-1:0]  mean_time_us;
		logic [TIME_W-1:0]  min_time_us;
		logic [TIME_W-1:0]  max_time_us;
		logic [RATE_W-1:0]  cur_rate;
		logic [RATE_W-1:0]  mean_rate;
		logic [RATE_W-1:0]  low_rate;
		logic [RATE_W-1:0]  high_rate;
		logic [COUNT_W-1:0] frames_seen;
		logic [TOTAL_W-1:0] elapsed_us;
	} stats_t;

endpackage

// ===== rtl/frame_time_window_stats.sv =====
// Frame time window statistics: sample ring, scan and shared divider sequencer.
// Depends on ftws_pkg and ftws_div.
//
// Usage
//   sample channel (sample_valid / sample_stall / sample): one word per frame.
//     mode record stores frame_time_us in a ring of the last WINDOW samples and
//     yields one stats word; mode clear empties the ring, zeroes the frame and
//     time counters and yields nothing.
//   stats channel (stats_valid / stats_stall / stats): current, mean, min and
//     max duration over the ring, Q8 frame rates of each, frame count, total time.
//   Sequence: a record word runs a ring scan of fill reads (one read a cycle
//     from the ring memory), five divisions on the one shared divider and
//     the output state; a division by a zero duration skips the divider.
//     A clear leaves the block idle, ready for the next word.
//   One word at a time: sample_stall is high from a record's acceptance until
//     its stats word moves into the output register.
//   The output register lets the next sample word in while a stats word waits.
//   Stall: while stats_stall holds a word, a finished result waits in the last
//     state; nothing is dropped.
//   Reset: ring empty, counters zero, no word pending. The ring memory itself is
//     not cleared; only entries written since the last clear are ever read.
module frame_time_window_stats (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  ftws_pkg::sample_t sample,
	output logic              stats_valid,
	input  logic              stats_stall,
	output ftws_pkg::stats_t  stats
);
	import ftws_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// window bookkeeping and running counters
	logic [FILL_W-1:0]  fill_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [COUNT_W-1:0] frame_q;
	logic [TOTAL_W-1:0] total_q;

	// ring memory, synchronous read
	logic [TIME_W-1:0] ring_mem [WINDOW];
	logic [SLOT_W-1:0] rd_addr_q;
	logic              issue_done_q;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [TIME_W-1:0] rd_data_s1;

	// per-word results
	logic [TIME_W-1:0] cur_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TIME_W-1:0] lo_q;
	logic [TIME_W-1:0] hi_q;
	logic [TIME_W-1:0] mean_q;
	logic [RATE_W-1:0] cur_rate_q;
	logic [RATE_W-1:0] mean_rate_q;
	logic [RATE_W-1:0] low_rate_q;
	logic [RATE_W-1:0] high_rate_q;
	div_op_t           op_q;
	div_op_t           op_next;

	stats_t stats_q;
	logic   stats_valid_q;

	logic               sample_fire;
	logic               rec_fire;
	logic               clr_fire;
	logic               issue;
	logic               issue_last;
	logic               out_free;
	logic [DIV_N_W-1:0] div_dividend;
	logic [DIV_D_W-1:0] div_divisor;
	logic               div_zero;
	logic               div_start;
	logic               div_done;
	logic [DIV_N_W-1:0] div_quotient;
	logic [DIV_N_W-1:0] store_val;
	logic               store_en;

	assign sample_stall = (state_q != ST_IDLE);
	assign sample_fire  = sample_valid && !sample_stall;
	assign rec_fire     = sample_fire && (sample.mode == MODE_RECORD);
	assign clr_fire     = sample_fire && (sample.mode == MODE_CLEAR);
	assign out_free     = !stats_valid_q || !stats_stall;

	// scan reads entries 0 .. fill-1, the write of this word landed at accept
	assign issue      = (state_q == ST_SCAN) && !issue_done_q;
	assign issue_last = (FILL_W'(rd_addr_q) == fill_q - 1'b1);

	// divider operand select
	always_comb begin
		div_dividend = DIV_N_W'(RATE_NUM);
		unique case (op_q)
			DIV_MEAN: begin
				div_dividend = DIV_N_W'(sum_q);
				div_divisor  = DIV_D_W'(fill_q);
			end
			DIV_CUR_RATE:  div_divisor = cur_q;
			DIV_MEAN_RATE: div_divisor = mean_q;
			DIV_LOW_RATE:  div_divisor = hi_q;
			DIV_HIGH_RATE: div_divisor = lo_q;
			default:       div_divisor = '0;
		endcase
	end

	always_comb begin
		unique case (op_q)
			DIV_MEAN:      op_next = DIV_CUR_RATE;
			DIV_CUR_RATE:  op_next = DIV_MEAN_RATE;
			DIV_MEAN_RATE: op_next = DIV_LOW_RATE;
			DIV_LOW_RATE:  op_next = DIV_HIGH_RATE;
			default:       op_next = DIV_MEAN;
		endcase
	end

	assign div_zero  = (div_divisor == '0);
	assign div_start = (state_q == ST_DIV) && !div_zero;
	assign store_en  = ((state_q == ST_DIV) && div_zero) || ((state_q == ST_WAIT) && div_done);
	assign store_val = div_zero ? '0 : div_quotient;

	ftws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (rec_fire) state_d = ST_SCAN;
			ST_SCAN: if (rd_vld_s1 && rd_last_s1) state_d = ST_DIV;
			ST_DIV: begin
				if (div_zero) begin
					state_d = (op_q == DIV_HIGH_RATE) ? ST_OUT : ST_DIV;
				end else begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: if (div_done) state_d = (op_q == DIV_HIGH_RATE) ? ST_OUT : ST_DIV;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fill_q        <= '0;
			slot_q        <= '0;
			frame_q       <= '0;
			total_q       <= '0;
			rd_addr_q     <= '0;
			issue_done_q  <= 1'b0;
			rd_vld_s1     <= 1'b0;
			rd_last_s1    <= 1'b0;
			op_q          <= DIV_MEAN;
			stats_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_fire) begin
				fill_q  <= '0;
				slot_q  <= '0;
				frame_q <= '0;
				total_q <= '0;
			end else if (rec_fire) begin
				slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
				if (fill_q != FILL_W'(WINDOW)) fill_q <= fill_q + 1'b1;
				frame_q <= frame_q + 1'b1;
				total_q <= total_q + TOTAL_W'(sample.frame_time_us);
			end

			if (rec_fire) begin
				rd_addr_q    <= '0;
				issue_done_q <= 1'b0;
				op_q         <= DIV_MEAN;
			end else if (issue) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (issue_last) issue_done_q <= 1'b1;
			end
			rd_vld_s1  <= issue;
			rd_last_s1 <= issue && issue_last;

			if (store_en) op_q <= op_next;

			if ((state_q == ST_OUT) && out_free) begin
				stats_valid_q <= 1'b1;
			end else if (!stats_stall) begin
				stats_valid_q <= 1'b0;
			end
		end
	end

	// ring memory ports
	always_ff @(posedge clk) begin
		if (rec_fire) ring_mem[slot_q] <= sample.frame_time_us;
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= ring_mem[rd_addr_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (rec_fire) begin
			cur_q <= sample.frame_time_us;
			sum_q <= '0;
			lo_q  <= MIN_CEILING;
			hi_q  <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data_s1);
			if (rd_data_s1 < lo_q) lo_q <= rd_data_s1;
			if (rd_data_s1 > hi_q) hi_q <= rd_data_s1;
		end

		if (store_en) begin
			unique case (op_q)
				DIV_MEAN:      mean_q      <= store_val[TIME_W-1:0];
				DIV_CUR_RATE:  cur_rate_q  <= store_val[RATE_W-1:0];
				DIV_MEAN_RATE: mean_rate_q <= store_val[RATE_W-1:0];
				DIV_LOW_RATE:  low_rate_q  <= store_val[RATE_W-1:0];
				DIV_HIGH_RATE: high_rate_q <= store_val[RATE_W-1:0];
				default:       ;
			endcase
		end

		if ((state_q == ST_OUT) && out_free) begin
			stats_q.cur_time_us  <= cur_q;
			stats_q.mean_time_us <= mean_q;
			stats_q.min_time_us  <= lo_q;
			stats_q.max_time_us  <= hi_q;
			stats_q.cur_rate     <= cur_rate_q;
			stats_q.mean_rate    <= mean_rate_q;
			stats_q.low_rate     <= low_rate_q;
			stats_q.high_rate    <= high_rate_q;
			stats_q.frames_seen  <= frame_q;
			stats_q.elapsed_us   <= total_q;
		end
	end

	assign stats_valid = stats_valid_q;
	assign stats       = stats_q;

endmodule

// ===== rtl/ftws_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ftws_pkg for operand widths.
module ftws_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ftws_pkg::DIV_N_W-1:0] dividend,
	input  logic [ftws_pkg::DIV_D_W-1:0] divisor,
	output logic                         done,
	output logic [ftws_pkg::DIV_N_W-1:0] quotient
);
	import ftws_pkg::*;

	logic                  run_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [DIV_D_W-1:0]    rem_q;
	logic [DIV_D_W-1:0]    dvs_q;
	logic [DIV_N_W-1:0]    quo_q;
	logic [DIV_D_W:0]      rem_sh;
	logic [DIV_D_W+1:0]    diff;
	logic                  fits;

	// quo_q shifts the dividend out at the top and the quotient in at the bottom
	assign rem_sh = {rem_q, quo_q[DIV_N_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign fits   = !diff[DIV_D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_STEP_W'(DIV_N_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/ftws_chk.sv =====
// Port-level checker for frame_time_window_stats, bound to the top level.
// Depends on ftws_pkg and frame_time_window_stats_macros.svh.
`include "frame_time_window_stats_macros.svh"

module ftws_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input ftws_pkg::sample_t sample,
	input logic              stats_valid,
	input logic              stats_stall,
	input ftws_pkg::stats_t  stats
);
	import ftws_pkg::*;

	// a clear never produces a word
	`FTWS_ASSERT_NEXT(a_clear_silent, clk, arst_n, sample_valid && !sample_stall && (sample.mode == MODE_CLEAR), !$rose(stats_valid))

	// a record keeps the block busy while it works
	`FTWS_ASSERT_NEXT(a_record_busy, clk, arst_n, sample_valid && !sample_stall && (sample.mode == MODE_RECORD), sample_stall)

	// window statistics are ordered
	`FTWS_ASSERT_NOW(a_min_mean_max, clk, arst_n, stats_valid, (stats.min_time_us <= stats.mean_time_us) && (stats.mean_time_us <= stats.max_time_us))

	// a held word stays put
	`FTWS_ASSERT_NEXT(a_out_hold, clk, arst_n, stats_valid && stats_stall, stats_valid && $stable(stats))

endmodule

bind frame_time_window_stats ftws_chk u_ftws_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for frame_time_window_stats: a directed table and then random frame times.
// Depends on ftws_pkg and the block; an in-bench window model predicts the untyped stats words.
module testbench;
	import ftws_pkg::*;

	localparam int RANDOM_WORDS = 1000;
	localparam int CALM_WORDS   = 100;   // tail of the run with no idling on either side
	localparam int HOLD_AT      = 300;   // words in before the long output hold-off
	localparam int HOLD_CYCLES  = 2000;  // several full-window records' worth of cycles
	localparam int DRAIN_CYCLES = 400;   // a bit more than one full-window record
	localparam int OWED_DEPTH   = 2048;  // more than every record word of the run
	localparam int ROW_DEPTH    = 32;    // room for the directed table

	// one row of the directed table; want is used only when typed is set
	typedef struct {
		sample_t word;
		bit      typed;
		stats_t  want;
	} step_t;

	logic    clk;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample;
	logic    stats_valid;
	logic    stats_stall;
	stats_t  stats;

	frame_time_window_stats uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.stats_valid  (stats_valid),
		.stats_stall  (stats_stall),
		.stats        (stats)
	);

	// window model state, mirrors the block's ring and counters
	logic [TIME_W-1:0]  ring [WINDOW];
	int                 fill;
	int                 slot;
	logic [COUNT_W-1:0] frames;
	logic [TOTAL_W-1:0] total;

	stats_t pending_stats [OWED_DEPTH];  // stats words still owed by the block
	int     pend_wr;                     // words owed so far
	int     pend_rd;                     // words checked so far
	step_t  directed [ROW_DEPTH];
	int     n_rows;
	int     errors;
	int     words_in;           // sample words accepted so far
	bit     calm;               // set for the last stretch: no gaps, no output stalls
	bit     tx_gaps;            // sender idles in this segment

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog; a correct run is several times shorter than this
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// floor(256e6 / d) as Q8 fps, zero duration gives zero
	function automatic logic [RATE_W-1:0] fps_q8(input logic [TIME_W-1:0] d);
		if (d == '0)
			return '0;
		return RATE_W'(64'(RATE_NUM) / 64'(d));
	endfunction

	function automatic void clear_window();
		fill   = 0;
		slot   = 0;
		frames = '0;
		total  = '0;
	endfunction

	// store one duration, rescan the held samples and build the stats word
	function automatic stats_t record_frame(input logic [TIME_W-1:0] d);
		stats_t            s;
		logic [63:0]       sum;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		logic [TIME_W-1:0] mean;
		sum = '0;
		lo  = MIN_CEILING;  // min never rises above the 9999 ms ceiling
		hi  = '0;
		ring[slot] = d;
		slot = (slot + 1) % WINDOW;
		if (fill < WINDOW)
			fill++;
		// only slots written since the last clear lie below fill
		for (int i = 0; i < fill; i++) begin
			sum = sum + 64'(ring[i]);
			if (ring[i] < lo)
				lo = ring[i];
			if (ring[i] > hi)
				hi = ring[i];
		end
		mean   = TIME_W'(sum / 64'(fill));
		frames = frames + 1'b1;
		total  = total + TOTAL_W'(d);
		s.cur_time_us  = d;
		s.mean_time_us = mean;
		s.min_time_us  = lo;
		s.max_time_us  = hi;
		s.cur_rate     = fps_q8(d);
		s.mean_rate    = fps_q8(mean);
		s.low_rate     = fps_q8(hi);   // slowest frame gives the low rate
		s.high_rate    = fps_q8(lo);
		s.frames_seen  = frames;
		s.elapsed_us   = total;
		return s;
	endfunction

	function automatic stats_t make_stats(input logic [63:0] cur, mean, lo, hi,
			cur_r, mean_r, low_r, high_r, n, elapsed);
		stats_t s;
		s.cur_time_us  = TIME_W'(cur);
		s.mean_time_us = TIME_W'(mean);
		s.min_time_us  = TIME_W'(lo);
		s.max_time_us  = TIME_W'(hi);
		s.cur_rate     = RATE_W'(cur_r);
		s.mean_rate    = RATE_W'(mean_r);
		s.low_rate     = RATE_W'(low_r);
		s.high_rate    = RATE_W'(high_r);
		s.frames_seen  = COUNT_W'(n);
		s.elapsed_us   = TOTAL_W'(elapsed);
		return s;
	endfunction

	function automatic void add_row(input logic m, input logic [TIME_W-1:0] t,
			input bit typed, input stats_t want);
		step_t r;
		r.word.mode          = m;
		r.word.frame_time_us = t;
		r.typed              = typed;
		r.want               = want;
		directed[n_rows]     = r;
		n_rows++;
	endfunction

	// mostly ordinary frame times, with zero, tiny, ceiling-edge, top-of-range and raw picks
	function automatic logic [TIME_W-1:0] pick_duration();
		case ($urandom_range(0, 9))
			0: return TIME_W'($urandom_range(0, 15));
			1: return TIME_W'($urandom);
			2: return MIN_CEILING - TIME_W'(10) + TIME_W'($urandom_range(0, 20));
			3: return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3));
			default: return TIME_W'($urandom_range(8000, 60000));
		endcase
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_stats(input stats_t want, got);
		check_field("cur_time_us", 64'(want.cur_time_us), 64'(got.cur_time_us));
		check_field("mean_time_us", 64'(want.mean_time_us), 64'(got.mean_time_us));
		check_field("min_time_us", 64'(want.min_time_us), 64'(got.min_time_us));
		check_field("max_time_us", 64'(want.max_time_us), 64'(got.max_time_us));
		check_field("cur_rate", 64'(want.cur_rate), 64'(got.cur_rate));
		check_field("mean_rate", 64'(want.mean_rate), 64'(got.mean_rate));
		check_field("low_rate", 64'(want.low_rate), 64'(got.low_rate));
		check_field("high_rate", 64'(want.high_rate), 64'(got.high_rate));
		check_field("frames_seen", 64'(want.frames_seen), 64'(got.frames_seen));
		check_field("elapsed_us", 64'(want.elapsed_us), 64'(got.elapsed_us));
	endtask

	// Offer one sample word, maybe after a gap, and hold it until accepted.
	// The model is stepped at the accepting edge; a clear owes no stats word.
	task automatic send_word(input sample_t w, input bit typed, input stats_t want);
		stats_t s;
		if (!calm && tx_gaps && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= w;
		do
			@(posedge clk);
		while (sample_stall);
		words_in++;
		if (w.mode == MODE_CLEAR) begin
			clear_window();
		end else begin
			s = record_frame(w.frame_time_us);
			pending_stats[pend_wr % OWED_DEPTH] = typed ? want : s;
			pend_wr++;
		end
	endtask

	// sender: directed table, then random words, then drain and verdict
	initial begin
		sample_t w;
		sample_valid <= 1'b0;
		sample       <= '0;
		errors   = 0;
		words_in = 0;
		n_rows   = 0;
		pend_wr  = 0;
		pend_rd  = 0;
		calm     = 1'b0;
		tx_gaps  = 1'b1;
		clear_window();

		// first record after reset: zero duration, every rate zero
		add_row(MODE_RECORD, 24'd0, 1'b1, make_stats(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
		add_row(MODE_RECORD, 24'hFFFFFF, 1'b0, '0);
		// clear carries a payload that must be ignored
		add_row(MODE_CLEAR, 24'hABCDEF, 1'b0, '0);
		// largest duration: min pinned at the ceiling
		add_row(MODE_RECORD, 24'hFFFFFF, 1'b1, make_stats(24'hFFFFFF, 24'hFFFFFF, 9999000,
			24'hFFFFFF, 15, 15, 15, 25, 1, 24'hFFFFFF));
		// smallest nonzero duration: largest rate
		add_row(MODE_RECORD, 24'd1, 1'b1, make_stats(1, 8388608, 1, 24'hFFFFFF,
			256000000, 30, 15, 256000000, 2, 48'h1000000));
		add_row(MODE_CLEAR, 24'd0, 1'b0, '0);
		// one sample above the ceiling, then samples just above, at and just below it
		add_row(MODE_RECORD, 24'd10000000, 1'b1, make_stats(10000000, 10000000, 9999000,
			10000000, 25, 25, 25, 25, 1, 10000000));
		add_row(MODE_RECORD, 24'd9999001, 1'b0, '0);
		add_row(MODE_RECORD, 24'd9999000, 1'b0, '0);
		add_row(MODE_RECORD, 24'd9998999, 1'b0, '0);
		add_row(MODE_CLEAR, 24'hFFFFFF, 1'b0, '0);
		add_row(MODE_RECORD, 24'd16667, 1'b0, '0);
		add_row(MODE_RECORD, 24'd33333, 1'b0, '0);
		add_row(MODE_RECORD, 24'h555555, 1'b0, '0);
		add_row(MODE_RECORD, 24'hAAAAAA, 1'b0, '0);
		add_row(MODE_RECORD, 24'd2, 1'b0, '0);
		add_row(MODE_RECORD, 24'd256, 1'b0, '0);
		// zero among nonzero samples: min and high rate drop to zero
		add_row(MODE_RECORD, 24'd0, 1'b0, '0);
		add_row(MODE_CLEAR, 24'd0, 1'b0, '0);
		add_row(MODE_RECORD, 24'd1, 1'b1, make_stats(1, 1, 1, 1, 256000000, 256000000,
			256000000, 256000000, 1, 1));

		wait (arst_n === 1'b1);
		@(posedge clk);

		for (int i = 0; i < n_rows; i++)
			send_word(directed[i].word, directed[i].typed, directed[i].want);

		// random part: clears are rare so the ring fills and wraps between them
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n >= RANDOM_WORDS - CALM_WORDS);
			if (n % 50 == 0)
				tx_gaps = $urandom_range(0, 1);
			w.mode          = ($urandom_range(0, 199) == 0) ? MODE_CLEAR : MODE_RECORD;
			w.frame_time_us = pick_duration();
			send_word(w, 1'b0, '0);
		end
		sample_valid <= 1'b0;

		while (pend_rd != pend_wr)
			@(posedge clk);
		// catch any stray word after the last one owed
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// receiver: checks each accepted stats word, stalls in bursts, and once
	// holds off long enough that the block backs up into its input
	initial begin
		stats_t want;
		int     stall_left;
		int     hold_left;
		int     cycle;
		bit     held;
		bit     rx_gaps;
		bit     nxt;
		stats_stall <= 1'b0;
		stall_left = 0;
		hold_left  = 0;
		cycle      = 0;
		held       = 1'b0;
		rx_gaps    = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stats_valid && !stats_stall) begin
				if (pend_rd == pend_wr) begin
					errors++;
					$display("%0t: stats word expected none got cur_time_us %0d",
						$time, stats.cur_time_us);
				end else begin
					want = pending_stats[pend_rd % OWED_DEPTH];
					pend_rd++;
					check_stats(want, stats);
				end
			end
			cycle++;
			if (cycle % 500 == 0)
				rx_gaps = $urandom_range(0, 1);
			if (!held && words_in >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				nxt = 1'b1;
			end else if (!calm && rx_gaps && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 7);
				nxt = 1'b1;
			end else begin
				nxt = 1'b0;
			end
			stats_stall <= nxt;
		end
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ftws_pkg.sv
rtl/ftws_div.sv
rtl/frame_time_window_stats.sv
rtl/ftws_chk.sv
bench/testbench.sv
